### src/wavelength_to_rgb_color_top_macros.svh
// Assertion helpers shared by the RTL.
`ifndef WAVELENGTH_TO_RGB_COLOR_TOP_MACROS_SVH
`define WAVELENGTH_TO_RGB_COLOR_TOP_MACROS_SVH
`ifndef SYNTH
`define WTRGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtrgb: same-cycle check failed");
`define WTRGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtrgb: next-cycle check failed");
`else
`define WTRGB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WTRGB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/wtrgb_pkg.sv
`timescale 1ns / 1ps
package wtrgb_pkg;

    localparam int GAMMA_INDEX_BITS = 10;
    localparam int WAVE_FRAC_BITS   = 4;
    localparam int WAVE_W           = 14;
    localparam int CH_W             = 8;

    // levels are Q1.16
    localparam int LVL_FRAC = 16;
    localparam int LVL_W    = LVL_FRAC + 1;
    localparam longint unsigned LVL_HALF = 64'd1 << (LVL_FRAC - 1);

    localparam longint unsigned NM_380 = 64'd380 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_420 = 64'd420 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_440 = 64'd440 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_490 = 64'd490 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_510 = 64'd510 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_580 = 64'd580 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_645 = 64'd645 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_700 = 64'd700 << WAVE_FRAC_BITS;
    localparam longint unsigned NM_780 = 64'd780 << WAVE_FRAC_BITS;

    localparam longint unsigned SP_20 = 64'd20 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_40 = 64'd40 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_50 = 64'd50 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_60 = 64'd60 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_65 = 64'd65 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_70 = 64'd70 << WAVE_FRAC_BITS;
    localparam longint unsigned SP_80 = 64'd80 << WAVE_FRAC_BITS;

    localparam int WX_W  = ($clog2(NM_780 + 64'd1) > WAVE_W) ? $clog2(NM_780 + 64'd1) : WAVE_W;
    localparam int OFF_W = $clog2(SP_80 + 64'd1);

    // divider numerator bound is the edge term at its widest span
    localparam longint unsigned NUM_MAX = ((64'd10 << LVL_FRAC) + 64'd5) * SP_80;
    localparam int DIV_NUM_W = $clog2(NUM_MAX + 64'd1);
    localparam int DIV_DEN_W = $clog2(64'd10 * SP_80 + 64'd1);

    localparam longint unsigned RCP_20  = (64'd1 << DIV_NUM_W) / SP_20;
    localparam longint unsigned RCP_50  = (64'd1 << DIV_NUM_W) / SP_50;
    localparam longint unsigned RCP_60  = (64'd1 << DIV_NUM_W) / SP_60;
    localparam longint unsigned RCP_65  = (64'd1 << DIV_NUM_W) / SP_65;
    localparam longint unsigned RCP_70  = (64'd1 << DIV_NUM_W) / SP_70;
    localparam longint unsigned RCP_E40 = (64'd1 << DIV_NUM_W) / (64'd10 * SP_40);
    localparam longint unsigned RCP_E80 = (64'd1 << DIV_NUM_W) / (64'd10 * SP_80);

    localparam int GAM_IDX_W = GAMMA_INDEX_BITS + 1;
    localparam int GAM_DEPTH = (1 << GAMMA_INDEX_BITS) + 1;
    localparam int GAM_SH    = LVL_FRAC - GAMMA_INDEX_BITS;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [CH_W-1:0] t_gam_rom [GAM_DEPTH];

    typedef enum logic [1:0] {LVL_ZERO, LVL_UNIT, LVL_RAMP} t_lvl;
    typedef enum logic [2:0] {RSP_60, RSP_50, RSP_20, RSP_70, RSP_65} t_rsp;
    typedef enum logic {ESP_LO, ESP_HI} t_esp;

    typedef struct packed {
        logic                 oor;
        t_lvl                 lvl_r;
        t_lvl                 lvl_g;
        t_lvl                 lvl_b;
        t_rsp                 rsp;
        t_esp                 esp;
        logic [DIV_NUM_W-1:0] rnum;
        logic [DIV_NUM_W-1:0] fnum;
    } t_ent;

    typedef struct packed {
        logic oor;
        t_lvl lvl_r;
        t_lvl lvl_g;
        t_lvl lvl_b;
    } t_side;

    // (2k-1)^5 * 2^(4G) <= 510^5 * i^4
    function automatic logic gamma_reaches(input logic [8:0] k, input logic [16:0] i);
        logic [127:0] a;
        logic [127:0] a5;
        logic [127:0] ii;
        logic [127:0] lhs;
        logic [127:0] rhs;
        a   = {119'd0, k} + {119'd0, k} - 128'd1;
        a5  = a * a * a * a * a;
        ii  = {111'd0, i};
        lhs = a5 << (4 * GAMMA_INDEX_BITS);
        rhs = 128'd34502525100000 * ii * ii * ii * ii;
        return lhs <= rhs;
    endfunction

    function automatic logic [CH_W-1:0] gamma_entry(input logic [16:0] i);
        logic [8:0] lo;
        logic [8:0] hi;
        logic [8:0] mid;
        lo  = 9'd0;
        hi  = 9'd255;
        mid = 9'd0;
        for (int s = 0; s < 9; s++) begin
            if (lo < hi) begin
                mid = 9'(({1'b0, lo} + {1'b0, hi} + 10'd1) >> 1);
                if (gamma_reaches(mid, i)) begin
                    lo = mid;
                end else begin
                    hi = mid - 9'd1;
                end
            end
        end
        return lo[CH_W-1:0];
    endfunction

    function automatic t_gam_rom gamma_rom_init();
        t_gam_rom rom;
        for (int i = 0; i < GAM_DEPTH; i++) begin
            rom[i] = gamma_entry(17'(i));
        end
        return rom;
    endfunction

endpackage

### src/wtrgb_front.sv
`timescale 1ns / 1ps
module wtrgb_front import wtrgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [WAVE_W-1:0] i_wavelength,
    input  logic              i_full,
    output logic              o_push,
    output t_ent              o_ent
);

    localparam logic [WX_W-1:0] C_380 = WX_W'(NM_380);
    localparam logic [WX_W-1:0] C_420 = WX_W'(NM_420);
    localparam logic [WX_W-1:0] C_440 = WX_W'(NM_440);
    localparam logic [WX_W-1:0] C_490 = WX_W'(NM_490);
    localparam logic [WX_W-1:0] C_510 = WX_W'(NM_510);
    localparam logic [WX_W-1:0] C_580 = WX_W'(NM_580);
    localparam logic [WX_W-1:0] C_645 = WX_W'(NM_645);
    localparam logic [WX_W-1:0] C_700 = WX_W'(NM_700);
    localparam logic [WX_W-1:0] C_780 = WX_W'(NM_780);

    logic                 r_fv;
    t_ent                 r_ent;
    logic                 accept;
    logic [WX_W-1:0]      wx;
    logic [OFF_W-1:0]     n_off;
    logic [OFF_W-1:0]     e_off;
    logic [DIV_NUM_W-1:0] half;
    logic [DIV_NUM_W-1:0] span;
    logic [DIV_NUM_W-1:0] ew;
    t_ent                 n_ent;

    assign o_busy = r_fv && i_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_fv && !i_full;
    assign o_ent  = r_ent;
    assign wx     = WX_W'(i_wavelength);

    always_comb begin
        n_ent.oor   = (wx < C_380) || (wx > C_780);
        n_ent.lvl_r = LVL_ZERO;
        n_ent.lvl_g = LVL_ZERO;
        n_ent.lvl_b = LVL_ZERO;
        n_ent.rsp   = RSP_60;
        n_ent.esp   = ESP_LO;
        n_off       = '0;
        e_off       = '0;
        if (!n_ent.oor) begin
            if (wx < C_440) begin
                n_off       = OFF_W'(C_440 - wx);
                n_ent.rsp   = RSP_60;
                n_ent.lvl_r = LVL_RAMP;
                n_ent.lvl_b = LVL_UNIT;
            end else if (wx < C_490) begin
                n_off       = OFF_W'(wx - C_440);
                n_ent.rsp   = RSP_50;
                n_ent.lvl_g = LVL_RAMP;
                n_ent.lvl_b = LVL_UNIT;
            end else if (wx < C_510) begin
                n_off       = OFF_W'(C_510 - wx);
                n_ent.rsp   = RSP_20;
                n_ent.lvl_g = LVL_UNIT;
                n_ent.lvl_b = LVL_RAMP;
            end else if (wx < C_580) begin
                n_off       = OFF_W'(wx - C_510);
                n_ent.rsp   = RSP_70;
                n_ent.lvl_r = LVL_RAMP;
                n_ent.lvl_g = LVL_UNIT;
            end else if (wx < C_645) begin
                n_off       = OFF_W'(C_645 - wx);
                n_ent.rsp   = RSP_65;
                n_ent.lvl_r = LVL_UNIT;
                n_ent.lvl_g = LVL_RAMP;
            end else begin
                n_ent.lvl_r = LVL_UNIT;
            end

            // full-span distance gives a factor of exactly one
            if (wx < C_420) begin
                e_off     = OFF_W'(wx - C_380);
                n_ent.esp = ESP_LO;
            end else if (wx < C_700) begin
                e_off     = OFF_W'(SP_40);
                n_ent.esp = ESP_LO;
            end else begin
                e_off     = OFF_W'(C_780 - wx);
                n_ent.esp = ESP_HI;
            end
        end

        case (n_ent.rsp)
            RSP_60:  half = DIV_NUM_W'(SP_60 >> 1);
            RSP_50:  half = DIV_NUM_W'(SP_50 >> 1);
            RSP_20:  half = DIV_NUM_W'(SP_20 >> 1);
            RSP_70:  half = DIV_NUM_W'(SP_70 >> 1);
            RSP_65:  half = DIV_NUM_W'(SP_65 >> 1);
            default: half = '0;
        endcase

        case (n_ent.esp)
            ESP_LO:  span = DIV_NUM_W'(SP_40);
            ESP_HI:  span = DIV_NUM_W'(SP_80);
            default: span = '0;
        endcase

        ew          = DIV_NUM_W'(e_off);
        n_ent.rnum  = (DIV_NUM_W'(n_off) << LVL_FRAC) + half;
        // 2^16 * (3E + 7e) + 5E
        n_ent.fnum  = ((((span << 1) + span) + ((ew << 3) - ew)) << LVL_FRAC)
                    + (span << 2) + span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (accept) begin
            r_fv <= 1'b1;
        end else if (o_push) begin
            r_fv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ent <= n_ent;
        end
    end

endmodule

### src/wtrgb_queue.sv
`timescale 1ns / 1ps
`include "wavelength_to_rgb_color_top_macros.svh"
module wtrgb_queue import wtrgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_ent i_ent,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_ent o_ent
);

    t_ent               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic [Q_PTR_W-1:0] n_wr;
    logic [Q_PTR_W-1:0] n_rd;
    logic [Q_CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    `WTRGB_ASSERT_IMP(a_q_no_overflow, i_clk, i_rst_n, i_push, r_cnt != Q_CNT_W'(Q_DEPTH))
    `WTRGB_ASSERT_IMP(a_q_no_underflow, i_clk, i_rst_n, i_pop, r_cnt != '0)

endmodule

### src/wtrgb_cdiv.sv
`timescale 1ns / 1ps
module wtrgb_cdiv import wtrgb_pkg::*; (
    input  logic                 i_clk,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    input  logic [DIV_NUM_W-1:0] i_rcp,
    output logic [LVL_W-1:0]     o_quo
);

    logic [DIV_NUM_W-1:0]   r_num;
    logic [DIV_DEN_W-1:0]   r_den;
    logic [2*DIV_NUM_W-1:0] r_prod;
    logic [LVL_W-1:0]       r_quo;
    logic [DIV_NUM_W-1:0]   q_est;
    logic [DIV_NUM_W-1:0]   den_w;
    logic [DIV_NUM_W-1:0]   qd;
    logic [DIV_NUM_W-1:0]   rem;
    logic [DIV_NUM_W-1:0]   n_quo;

    // reciprocal estimate is low by at most one
    always_comb begin
        q_est = r_prod[2*DIV_NUM_W-1:DIV_NUM_W];
        den_w = DIV_NUM_W'(r_den);
        qd    = q_est * den_w;
        rem   = r_num - qd;
        n_quo = q_est + DIV_NUM_W'(rem >= den_w);
    end

    always_ff @(posedge i_clk) begin
        r_num  <= i_num;
        r_den  <= i_den;
        r_prod <= (2*DIV_NUM_W)'(i_num) * (2*DIV_NUM_W)'(i_rcp);
        r_quo  <= n_quo[LVL_W-1:0];
    end

    assign o_quo = r_quo;

endmodule

### src/wtrgb_back.sv
`timescale 1ns / 1ps
`include "wavelength_to_rgb_color_top_macros.svh"
module wtrgb_back import wtrgb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_ent            i_ent,
    output logic            o_pop,
    output logic            o_valid,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue,
    output logic            o_out_of_range
);

    localparam t_gam_rom GAMMA_ROM = gamma_rom_init();

    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic                   r_v4;
    logic                   r_vo;
    t_side                  r_s1;
    t_side                  r_s2;
    t_side                  r_s3;
    t_side                  r_s4;
    logic [LVL_W-1:0]       r_p;
    logic [LVL_W-1:0]       r_f;
    logic [CH_W-1:0]        r_gp;
    logic [CH_W-1:0]        r_gf;
    logic [CH_W-1:0]        r_red;
    logic [CH_W-1:0]        r_green;
    logic [CH_W-1:0]        r_blue;
    logic                   r_oor;
    logic [DIV_DEN_W-1:0]   rden;
    logic [DIV_NUM_W-1:0]   rrcp;
    logic [DIV_DEN_W-1:0]   fden;
    logic [DIV_NUM_W-1:0]   frcp;
    logic [LVL_W-1:0]       ramp;
    logic [LVL_W-1:0]       fac;
    logic [2*LVL_W-1:0]     prod;
    logic [2*LVL_W-1:0]     rnd;
    t_side                  side_in;

    function automatic logic [CH_W-1:0] pick(input t_lvl lvl, input logic [CH_W-1:0] gp,
                                             input logic [CH_W-1:0] gf);
        logic [CH_W-1:0] v;
        case (lvl)
            LVL_RAMP: v = gp;
            LVL_UNIT: v = gf;
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign o_pop = i_valid;

    always_comb begin
        side_in.oor   = i_ent.oor;
        side_in.lvl_r = i_ent.lvl_r;
        side_in.lvl_g = i_ent.lvl_g;
        side_in.lvl_b = i_ent.lvl_b;

        case (i_ent.rsp)
            RSP_60: begin
                rden = DIV_DEN_W'(SP_60);
                rrcp = DIV_NUM_W'(RCP_60);
            end
            RSP_50: begin
                rden = DIV_DEN_W'(SP_50);
                rrcp = DIV_NUM_W'(RCP_50);
            end
            RSP_20: begin
                rden = DIV_DEN_W'(SP_20);
                rrcp = DIV_NUM_W'(RCP_20);
            end
            RSP_70: begin
                rden = DIV_DEN_W'(SP_70);
                rrcp = DIV_NUM_W'(RCP_70);
            end
            RSP_65: begin
                rden = DIV_DEN_W'(SP_65);
                rrcp = DIV_NUM_W'(RCP_65);
            end
            default: begin
                rden = DIV_DEN_W'(SP_60);
                rrcp = DIV_NUM_W'(RCP_60);
            end
        endcase

        case (i_ent.esp)
            ESP_LO: begin
                fden = DIV_DEN_W'(64'd10 * SP_40);
                frcp = DIV_NUM_W'(RCP_E40);
            end
            ESP_HI: begin
                fden = DIV_DEN_W'(64'd10 * SP_80);
                frcp = DIV_NUM_W'(RCP_E80);
            end
            default: begin
                fden = DIV_DEN_W'(64'd10 * SP_40);
                frcp = DIV_NUM_W'(RCP_E40);
            end
        endcase
    end

    wtrgb_cdiv u_ramp_div (
        .i_clk (i_clk),
        .i_num (i_ent.rnum),
        .i_den (rden),
        .i_rcp (rrcp),
        .o_quo (ramp)
    );

    wtrgb_cdiv u_edge_div (
        .i_clk (i_clk),
        .i_num (i_ent.fnum),
        .i_den (fden),
        .i_rcp (frcp),
        .o_quo (fac)
    );

    assign prod = (2*LVL_W)'(ramp) * (2*LVL_W)'(fac);
    assign rnd  = prod + (2*LVL_W)'(LVL_HALF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_vo <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1    <= side_in;
        r_s2    <= r_s1;
        r_s3    <= r_s2;
        r_s4    <= r_s3;
        r_p     <= rnd[LVL_FRAC +: LVL_W];
        r_f     <= fac;
        r_gp    <= GAMMA_ROM[r_p[LVL_W-1:GAM_SH]];
        r_gf    <= GAMMA_ROM[r_f[LVL_W-1:GAM_SH]];
        r_red   <= pick(r_s4.lvl_r, r_gp, r_gf);
        r_green <= pick(r_s4.lvl_g, r_gp, r_gf);
        r_blue  <= pick(r_s4.lvl_b, r_gp, r_gf);
        r_oor   <= r_s4.oor;
    end

    assign o_valid        = r_vo;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_out_of_range = r_oor;

    `WTRGB_ASSERT_IMP(a_oor_black, i_clk, i_rst_n, r_vo && r_oor, (r_red == '0) && (r_green == '0) && (r_blue == '0))
    `WTRGB_ASSERT_IMP(a_one_ramp, i_clk, i_rst_n, i_valid, $countones({i_ent.lvl_r == LVL_RAMP, i_ent.lvl_g == LVL_RAMP, i_ent.lvl_b == LVL_RAMP}) <= 1)

endmodule

### src/wavelength_to_rgb_color_top.sv
`timescale 1ns / 1ps
// Wavelength to RGB colour map.
// Input: i_wavelength in 1/16 nm, taken on a rising edge with start high and
// busy low. Output: o_red, o_green, o_blue and o_out_of_range, shown for one
// cycle with o_valid high; the receiver takes every result as it comes.
// Throughput: one item per clock while busy is low. Front end classifies
// the wavelength into its colour segment and edge region and registers the
// divider numerators; a two-entry queue sits between it and the back end.
// Path: the strobe follows the accepting edge through the front register,
// queue, two divider stages (reciprocal multiply, then one correction),
// intensity multiply, gamma ROM read and output register.
// busy rises only when the front register holds an item and the queue is
// full; the back end drains one item a cycle, so it stays low in practice.
// Wavelengths below 380 nm or above 780 nm give black with o_out_of_range.
// Synchronous active-low reset empties the queue and clears every valid bit;
// the first item may be started in the cycle after reset is released.
module wavelength_to_rgb_color_top import wtrgb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WAVE_W-1:0] i_wavelength,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_red,
    output logic [CH_W-1:0]   o_green,
    output logic [CH_W-1:0]   o_blue,
    output logic              o_out_of_range
);

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_ent f_ent;
    t_ent q_ent;

    wtrgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_wavelength (i_wavelength),
        .i_full       (full),
        .o_push       (push),
        .o_ent        (f_ent)
    );

    wtrgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ent   (f_ent),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_ent   (q_ent)
    );

    wtrgb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_ent          (q_ent),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_out_of_range (o_out_of_range)
    );

endmodule
